[rtl/core/sle_pkg.sv]
// sle_pkg: sizes, codes, state encoding and controller/datapath handshake types
// for the sequential list engine. No dependencies; every other file but sle_ram uses it.

package sle_pkg;

  localparam int unsigned DEPTH      = 64;
  localparam int unsigned WORD_WIDTH = 32;

  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

  // fixed field widths of the channels
  localparam int unsigned OP_W     = 2;
  localparam int unsigned POS_W    = 7;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned LEN_W    = 7;

  // common width for position / length compares
  localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_READ   = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_SH_RD,
    S_SH_WR,
    S_PLACE,
    S_RD_ISSUE,
    S_RD_WAIT,
    S_FINISH
  } state_e;

  // walking index updates
  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_TOP,   // last used entry, count-1
    IDX_NEXT,  // entry after the deleted one, pos
    IDX_POS,   // addressed entry, pos-1
    IDX_INC,
    IDX_DEC
  } idx_op_e;

  typedef enum logic [1:0] {
    WR_APPEND,   // word at count
    WR_PLACE,    // word at pos-1
    WR_SHIFT_UP, // read data at idx+1
    WR_SHIFT_DN  // read data at idx-1
  } wr_sel_e;

  typedef struct packed {
    logic    latch_req;
    logic    wr_en;
    wr_sel_e wr_sel;
    logic    rd_en;
    idx_op_e idx_op;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    set_status;
    status_e status;
    logic    capture_rd;
    logic    load_result;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic full;
    logic pos_ok;
    logic pos_is_last;
    logic idx_at_pos;   // idx == pos-1
    logic idx_at_tail;  // idx == count-1
    logic out_free;
  } sts_t;

endpackage

[rtl/core/sle_if.sv]
// sle_req_if / sle_rsp_if: valid-ready channels of the sequential list engine.
// Depends on sle_pkg for field widths.

interface sle_req_if;
  logic                        valid;
  logic                        ready;
  logic [sle_pkg::OP_W-1:0]    op;
  logic [sle_pkg::POS_W-1:0]   position;
  logic [sle_pkg::VALUE_W-1:0] item_value;

  modport source (output valid, op, position, item_value, input ready);
  modport sink   (input valid, op, position, item_value, output ready);
endinterface

interface sle_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [sle_pkg::STATUS_W-1:0] status;
  logic [sle_pkg::VALUE_W-1:0]  read_value;
  logic [sle_pkg::LEN_W-1:0]    list_length;

  modport source (output valid, status, read_value, list_length, input ready);
  modport sink   (input valid, status, read_value, list_length, output ready);
endinterface

[rtl/core/sle_ram.sv]
// sle_ram: generic simple dual-port RAM, one write and one registered read per cycle.
// No dependencies.

module sle_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/sle_datapath.sv]
// sle_datapath: request registers, entry count, walking index, entry RAM and
// the result register. Depends on sle_pkg and sle_ram.

module sle_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [sle_pkg::OP_W-1:0]      op_i,
  input  logic [sle_pkg::POS_W-1:0]     position_i,
  input  logic [sle_pkg::VALUE_W-1:0]   item_value_i,
  input  sle_pkg::cmd_t                 cmd_i,
  output sle_pkg::sts_t                 sts_o,
  output logic                          rsp_valid_o,
  input  logic                          rsp_ready_i,
  output logic [sle_pkg::STATUS_W-1:0]  rsp_status_o,
  output logic [sle_pkg::VALUE_W-1:0]   rsp_read_value_o,
  output logic [sle_pkg::LEN_W-1:0]     rsp_list_length_o
);

  sle_pkg::op_e                      op_q;
  logic [sle_pkg::POS_W-1:0]         pos_q;
  logic [sle_pkg::WORD_WIDTH-1:0]    word_q;
  logic [sle_pkg::CNT_W-1:0]         count_q;
  logic [sle_pkg::ADDR_W-1:0]        idx_q, idx_d;
  sle_pkg::status_e                  res_status_q;
  logic [sle_pkg::WORD_WIDTH-1:0]    res_value_q;

  logic                              out_valid_q;
  logic [sle_pkg::STATUS_W-1:0]      out_status_q;
  logic [sle_pkg::VALUE_W-1:0]       out_value_q;
  logic [sle_pkg::LEN_W-1:0]         out_len_q;

  logic [sle_pkg::CMP_W-1:0]         pos_cmp, cnt_cmp;
  logic [sle_pkg::ADDR_W-1:0]        pos_m1, cnt_m1;
  logic                              ram_we;
  logic [sle_pkg::ADDR_W-1:0]        ram_waddr;
  logic [sle_pkg::WORD_WIDTH-1:0]    ram_wdata;
  logic [sle_pkg::WORD_WIDTH-1:0]    ram_rdata;

  assign pos_cmp = sle_pkg::CMP_W'(pos_q);
  assign cnt_cmp = sle_pkg::CMP_W'(count_q);
  assign pos_m1  = sle_pkg::ADDR_W'(pos_q - sle_pkg::POS_W'(1));
  assign cnt_m1  = sle_pkg::ADDR_W'(count_q - sle_pkg::CNT_W'(1));

  assign sts_o.op          = op_q;
  assign sts_o.full        = cnt_cmp >= sle_pkg::CMP_W'(sle_pkg::DEPTH);
  assign sts_o.pos_ok      = (pos_q != '0) && (pos_cmp <= cnt_cmp);
  assign sts_o.pos_is_last = pos_cmp == cnt_cmp;
  assign sts_o.idx_at_pos  = idx_q == pos_m1;
  assign sts_o.idx_at_tail = idx_q == cnt_m1;
  assign sts_o.out_free    = !out_valid_q || rsp_ready_i;

  // request registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_req) begin
      op_q   <= sle_pkg::op_e'(op_i);
      pos_q  <= position_i;
      word_q <= sle_pkg::WORD_WIDTH'(item_value_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.cnt_inc) begin
      count_q <= count_q + sle_pkg::CNT_W'(1);
    end else if (cmd_i.cnt_dec) begin
      count_q <= count_q - sle_pkg::CNT_W'(1);
    end
  end

  always_comb begin
    unique case (cmd_i.idx_op)
      sle_pkg::IDX_TOP:  idx_d = cnt_m1;
      sle_pkg::IDX_NEXT: idx_d = sle_pkg::ADDR_W'(pos_q);
      sle_pkg::IDX_POS:  idx_d = pos_m1;
      sle_pkg::IDX_INC:  idx_d = idx_q + sle_pkg::ADDR_W'(1);
      sle_pkg::IDX_DEC:  idx_d = idx_q - sle_pkg::ADDR_W'(1);
      default:           idx_d = idx_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
  end

  // result being built
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_req) begin
      res_status_q <= sle_pkg::ST_DONE;
      res_value_q  <= '0;
    end else begin
      if (cmd_i.set_status) begin
        res_status_q <= cmd_i.status;
      end
      if (cmd_i.capture_rd) begin
        res_value_q <= ram_rdata;
      end
    end
  end

  always_comb begin
    ram_we = cmd_i.wr_en;
    unique case (cmd_i.wr_sel)
      sle_pkg::WR_APPEND: begin
        ram_waddr = sle_pkg::ADDR_W'(count_q);
        ram_wdata = word_q;
      end
      sle_pkg::WR_PLACE: begin
        ram_waddr = pos_m1;
        ram_wdata = word_q;
      end
      sle_pkg::WR_SHIFT_UP: begin
        ram_waddr = idx_q + sle_pkg::ADDR_W'(1);
        ram_wdata = ram_rdata;
      end
      default: begin
        ram_waddr = idx_q - sle_pkg::ADDR_W'(1);
        ram_wdata = ram_rdata;
      end
    endcase
  end

  sle_ram #(
    .WIDTH (sle_pkg::WORD_WIDTH),
    .DEPTH (sle_pkg::DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  // output register, free again on the cycle of its transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_result) begin
      out_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_result) begin
      out_status_q <= res_status_q;
      out_value_q  <= sle_pkg::VALUE_W'(res_value_q);
      out_len_q    <= sle_pkg::LEN_W'(count_q);
    end
  end

  assign rsp_valid_o       = out_valid_q;
  assign rsp_status_o      = out_status_q;
  assign rsp_read_value_o  = out_value_q;
  assign rsp_list_length_o = out_len_q;

endmodule

[rtl/core/sle_ctrl.sv]
// sle_ctrl: controller state machine that sequences one list operation.
// Depends on sle_pkg; drives the datapath only through cmd_t / sts_t.

module sle_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  input  sle_pkg::sts_t sts_i,
  output sle_pkg::cmd_t cmd_o
);

  sle_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sle_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    req_ready_o  = 1'b0;
    cmd_o        = '0;
    cmd_o.status = sle_pkg::ST_DONE;
    cmd_o.idx_op = sle_pkg::IDX_HOLD;
    cmd_o.wr_sel = sle_pkg::WR_APPEND;

    unique case (state_q)
      sle_pkg::S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.latch_req = 1'b1;
          state_d         = sle_pkg::S_DECIDE;
        end
      end

      sle_pkg::S_DECIDE: begin
        state_d = sle_pkg::S_FINISH;
        unique case (sts_i.op)
          sle_pkg::OP_APPEND: begin
            if (sts_i.full) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = sle_pkg::ST_FULL;
            end else begin
              cmd_o.wr_en   = 1'b1;
              cmd_o.wr_sel  = sle_pkg::WR_APPEND;
              cmd_o.cnt_inc = 1'b1;
            end
          end
          sle_pkg::OP_INSERT: begin
            // full is checked before the position
            if (sts_i.full) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = sle_pkg::ST_FULL;
            end else if (!sts_i.pos_ok) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = sle_pkg::ST_RANGE;
            end else begin
              cmd_o.idx_op = sle_pkg::IDX_TOP;
              state_d      = sle_pkg::S_SH_RD;
            end
          end
          sle_pkg::OP_DELETE: begin
            if (!sts_i.pos_ok) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = sle_pkg::ST_RANGE;
            end else if (sts_i.pos_is_last) begin
              cmd_o.cnt_dec = 1'b1;
            end else begin
              cmd_o.idx_op = sle_pkg::IDX_NEXT;
              state_d      = sle_pkg::S_SH_RD;
            end
          end
          default: begin
            if (!sts_i.pos_ok) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = sle_pkg::ST_RANGE;
            end else begin
              cmd_o.idx_op = sle_pkg::IDX_POS;
              state_d      = sle_pkg::S_RD_ISSUE;
            end
          end
        endcase
      end

      sle_pkg::S_SH_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = sle_pkg::S_SH_WR;
      end

      sle_pkg::S_SH_WR: begin
        cmd_o.wr_en = 1'b1;
        if (sts_i.op == sle_pkg::OP_INSERT) begin
          // walk down from the tail, moving each entry up one place
          cmd_o.wr_sel = sle_pkg::WR_SHIFT_UP;
          if (sts_i.idx_at_pos) begin
            state_d = sle_pkg::S_PLACE;
          end else begin
            cmd_o.idx_op = sle_pkg::IDX_DEC;
            state_d      = sle_pkg::S_SH_RD;
          end
        end else begin
          // walk up toward the tail, moving each entry down one place
          cmd_o.wr_sel = sle_pkg::WR_SHIFT_DN;
          if (sts_i.idx_at_tail) begin
            cmd_o.cnt_dec = 1'b1;
            state_d       = sle_pkg::S_FINISH;
          end else begin
            cmd_o.idx_op = sle_pkg::IDX_INC;
            state_d      = sle_pkg::S_SH_RD;
          end
        end
      end

      sle_pkg::S_PLACE: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_sel  = sle_pkg::WR_PLACE;
        cmd_o.cnt_inc = 1'b1;
        state_d       = sle_pkg::S_FINISH;
      end

      sle_pkg::S_RD_ISSUE: begin
        cmd_o.rd_en = 1'b1;
        state_d     = sle_pkg::S_RD_WAIT;
      end

      sle_pkg::S_RD_WAIT: begin
        cmd_o.capture_rd = 1'b1;
        state_d          = sle_pkg::S_FINISH;
      end

      sle_pkg::S_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.load_result = 1'b1;
          state_d           = sle_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = sle_pkg::S_IDLE;
      end
    endcase
  end

endmodule

[rtl/core/sequential_list_engine.sv]
// sequential_list_engine: ordered list of up to DEPTH words in one entry RAM.
// Append and failed operations pass from decide straight to finish; read adds a registered
// RAM read; insert and delete add a shift walk, and insert then places the new word.
// Shifts walk the RAM one entry at a time (registered read, then write).
// One request at a time; a new one is taken while the last result waits to transfer.
// Reset (async, active low) empties the list; RAM contents are left as they are.

module sequential_list_engine (
  input  logic       clk_i,
  input  logic       rst_ni,
  sle_req_if.sink    req_i,
  sle_rsp_if.source  rsp_o
);

  sle_pkg::cmd_t ctl_cmd;
  sle_pkg::sts_t dp_sts;

  sle_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .sts_i       (dp_sts),
    .cmd_o       (ctl_cmd)
  );

  sle_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .op_i              (req_i.op),
    .position_i        (req_i.position),
    .item_value_i      (req_i.item_value),
    .cmd_i             (ctl_cmd),
    .sts_o             (dp_sts),
    .rsp_valid_o       (rsp_o.valid),
    .rsp_ready_i       (rsp_o.ready),
    .rsp_status_o      (rsp_o.status),
    .rsp_read_value_o  (rsp_o.read_value),
    .rsp_list_length_o (rsp_o.list_length)
  );

  // one request in flight at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> !req_i.ready)
    else $error("request taken while another is in progress");

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> int'(rsp_o.list_length) <= sle_pkg::DEPTH)
    else $error("list length above capacity");

  a_fail_no_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.status != sle_pkg::ST_DONE |-> rsp_o.read_value == '0)
    else $error("failed operation returned a word");

  a_result_from_ctrl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_o.valid) |-> $past(ctl_cmd.load_result))
    else $error("result appeared without a load");

endmodule

[tb/sle_list_checker.sv]
`timescale 1ns / 1ps
// sle_list_checker: watches both channels of the sequential list engine and keeps a
// shadow copy of the list, so each result is checked against its expected value.
// Depends on sle_pkg and the sle_req_if / sle_rsp_if interfaces.

module sle_list_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  sle_req_if                        req_i,
  sle_rsp_if                        rsp_i,
  output int unsigned               error_count_o,
  output int unsigned               pending_o,
  output logic [sle_pkg::LEN_W-1:0] list_length_o
);

  typedef struct packed {
    sle_pkg::status_e             status;
    logic [sle_pkg::VALUE_W-1:0]  read_value;
    logic [sle_pkg::LEN_W-1:0]    list_length;
  } list_result_t;

  list_result_t                   expected_q[$];
  logic [sle_pkg::WORD_WIDTH-1:0] shadow_words [sle_pkg::DEPTH];
  int unsigned                    shadow_len;
  int unsigned                    error_count = 0;
  int unsigned                    result_index = 0;

  assign error_count_o = error_count;

  task automatic report_mismatch(string what, logic [sle_pkg::VALUE_W-1:0] expected,
                                 logic [sle_pkg::VALUE_W-1:0] actual);
    $display("[%0t] result %0d: %s mismatch, expected 0x%0h got 0x%0h",
             $realtime, result_index, what, expected, actual);
    error_count++;
  endtask

  // applies one operation to the shadow list and returns what the block must answer
  function automatic list_result_t apply_list_op(sle_pkg::op_e op, int unsigned pos,
                                                 logic [sle_pkg::VALUE_W-1:0] word);
    list_result_t res;
    bit           in_range;
    int           i;
    res.status     = sle_pkg::ST_DONE;
    res.read_value = '0;
    in_range = (pos >= 1) && (pos <= shadow_len);
    case (op)
      sle_pkg::OP_APPEND: begin
        if (shadow_len >= sle_pkg::DEPTH) begin
          res.status = sle_pkg::ST_FULL;
        end else begin
          shadow_words[shadow_len] = word[sle_pkg::WORD_WIDTH-1:0];
          shadow_len++;
        end
      end
      sle_pkg::OP_INSERT: begin
        if (shadow_len >= sle_pkg::DEPTH) begin
          res.status = sle_pkg::ST_FULL;
        end else if (!in_range) begin
          res.status = sle_pkg::ST_RANGE;
        end else begin
          for (i = int'(shadow_len); i >= int'(pos); i--) begin
            shadow_words[i] = shadow_words[i-1];
          end
          shadow_words[pos-1] = word[sle_pkg::WORD_WIDTH-1:0];
          shadow_len++;
        end
      end
      sle_pkg::OP_DELETE: begin
        if (!in_range) begin
          res.status = sle_pkg::ST_RANGE;
        end else begin
          for (i = int'(pos); i < int'(shadow_len); i++) begin
            shadow_words[i-1] = shadow_words[i];
          end
          shadow_len--;
        end
      end
      default: begin
        if (!in_range) begin
          res.status = sle_pkg::ST_RANGE;
        end else begin
          res.read_value = sle_pkg::VALUE_W'(shadow_words[pos-1]);
        end
      end
    endcase
    res.list_length = shadow_len[sle_pkg::LEN_W-1:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    list_result_t exp_res;
    if (!rst_ni) begin
      shadow_len = 0;
      expected_q.delete();
      pending_o     <= 0;
      list_length_o <= '0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result, status", '0,
                          sle_pkg::VALUE_W'(rsp_i.status));
        end else begin
          exp_res = expected_q.pop_front();
          if (rsp_i.status !== exp_res.status)
            report_mismatch("status", sle_pkg::VALUE_W'(exp_res.status),
                            sle_pkg::VALUE_W'(rsp_i.status));
          if (rsp_i.read_value !== exp_res.read_value)
            report_mismatch("read_value", exp_res.read_value, rsp_i.read_value);
          if (rsp_i.list_length !== exp_res.list_length)
            report_mismatch("list_length", sle_pkg::VALUE_W'(exp_res.list_length),
                            sle_pkg::VALUE_W'(rsp_i.list_length));
        end
        result_index++;
      end
      if (req_i.valid && req_i.ready) begin
        expected_q.push_back(apply_list_op(sle_pkg::op_e'(req_i.op), 32'(req_i.position),
                                           req_i.item_value));
      end
      pending_o     <= expected_q.size();
      list_length_o <= shadow_len[sle_pkg::LEN_W-1:0];
    end
  end

endmodule

[tb/tb_sequential_list_engine.sv]
`timescale 1ns / 1ps
// tb_sequential_list_engine: drives list operations into the engine with bursty traffic
// and a stalling receiver; sle_list_checker predicts and compares every result.
// Depends on sle_pkg, the channel interfaces, the engine and sle_list_checker.

module tb_sequential_list_engine;

  localparam int unsigned RANDOM_ITEMS     = 750;
  localparam int unsigned CYCLE_LIMIT      = 400000;
  localparam int unsigned LONG_HOLD_CYCLES = 300;
  localparam int unsigned SETTLE_CYCLES    = 200;  // above the slowest shift of a full list

  typedef enum logic [1:0] {
    SEG_GROW,
    SEG_SHRINK,
    SEG_MIX
  } segment_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  sle_req_if req_if();
  sle_rsp_if rsp_if();

  int unsigned               fail_count;
  int unsigned               pending;
  logic [sle_pkg::LEN_W-1:0] shadow_length;
  int unsigned               cycle_count = 0;
  int unsigned               burst_left;
  bit                        gapless = 1'b0;
  logic                      long_hold_req = 1'b0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  sequential_list_engine dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  sle_list_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req_if),
    .rsp_i         (rsp_if),
    .error_count_o (fail_count),
    .pending_o     (pending),
    .list_length_o (shadow_length)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver: random ready modes, plus one long hold-off on request
  initial begin
    int unsigned mode;
    int unsigned mode_left;
    bit          hold_served;
    mode_left   = 0;
    mode        = 0;
    hold_served = 1'b0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold_req && !hold_served) begin
        rsp_if.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk_i);
        hold_served = 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 2);
          mode_left = $urandom_range(5, 60);
        end
        mode_left--;
        case (mode)
          0:       rsp_if.ready <= 1'b1;
          1:       rsp_if.ready <= 1'($urandom_range(0, 1));
          default: rsp_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // offers one request, waits for its transfer, then maybe ends the burst with a gap
  task automatic send_item(sle_pkg::op_e op, logic [sle_pkg::POS_W-1:0] pos,
                           logic [sle_pkg::VALUE_W-1:0] word);
    req_if.valid      <= 1'b1;
    req_if.op         <= op;
    req_if.position   <= pos;
    req_if.item_value <= word;
    do @(posedge clk_i); while (!req_if.ready);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0 && !gapless) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = $urandom_range(1, 40);
    end
  endtask

  task automatic drain_results();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    @(posedge clk_i);
  endtask

  function automatic sle_pkg::op_e pick_op(segment_e kind);
    int unsigned r;
    r = $urandom_range(0, 99);
    case (kind)
      SEG_GROW:
        return (r < 45) ? sle_pkg::OP_APPEND : (r < 85) ? sle_pkg::OP_INSERT :
               (r < 93) ? sle_pkg::OP_READ : sle_pkg::OP_DELETE;
      SEG_SHRINK:
        return (r < 70) ? sle_pkg::OP_DELETE : (r < 80) ? sle_pkg::OP_READ :
               (r < 90) ? sle_pkg::OP_APPEND : sle_pkg::OP_INSERT;
      default:
        return sle_pkg::op_e'(r[1:0]);
    endcase
  endfunction

  // mostly valid positions, with the boundaries and wild values mixed in
  function automatic logic [sle_pkg::POS_W-1:0] pick_position(int unsigned len);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return sle_pkg::POS_W'($urandom_range(1, (len > 0) ? len : 1));
    if (r < 83) return '0;
    if (r < 91) return sle_pkg::POS_W'(len + 1);
    if (r < 95) return sle_pkg::POS_W'(len);
    return sle_pkg::POS_W'($urandom_range(0, 127));
  endfunction

  initial begin
    int unsigned sent;
    int unsigned seg_index;
    int unsigned seg_len;
    segment_e    kind;
    req_if.valid      <= 1'b0;
    req_if.op         <= sle_pkg::OP_APPEND;
    req_if.position   <= '0;
    req_if.item_value <= '0;
    burst_left = $urandom_range(1, 40);
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty list: every positioned operation is out of range
    send_item(sle_pkg::OP_READ,   7'd1, 32'h0);
    send_item(sle_pkg::OP_DELETE, 7'd1, 32'h0);
    send_item(sle_pkg::OP_INSERT, 7'd1, 32'hdead_beef);
    send_item(sle_pkg::OP_APPEND, 7'd0, 32'h0000_0000);
    send_item(sle_pkg::OP_APPEND, 7'd127, 32'hffff_ffff);
    send_item(sle_pkg::OP_APPEND, 7'd3, 32'ha5a5_a5a5);
    send_item(sle_pkg::OP_INSERT, 7'd1, 32'h5a5a_5a5a);   // new head
    send_item(sle_pkg::OP_INSERT, 7'd4, 32'h1234_5678);   // in front of the last entry
    send_item(sle_pkg::OP_INSERT, 7'd0, 32'h1111_1111);
    send_item(sle_pkg::OP_INSERT, 7'd6, 32'h2222_2222);   // one past the end is not allowed
    send_item(sle_pkg::OP_READ,   7'd1, 32'h0);
    send_item(sle_pkg::OP_READ,   7'd5, 32'h0);
    send_item(sle_pkg::OP_READ,   7'd0, 32'h0);
    send_item(sle_pkg::OP_READ,   7'd6, 32'h0);
    send_item(sle_pkg::OP_READ,   7'd127, 32'hffff_ffff);
    send_item(sle_pkg::OP_DELETE, 7'd127, 32'h0);
    send_item(sle_pkg::OP_DELETE, 7'd0, 32'h0);
    send_item(sle_pkg::OP_DELETE, 7'd5, 32'h0);
    send_item(sle_pkg::OP_DELETE, 7'd1, 32'h0);
    send_item(sle_pkg::OP_DELETE, 7'd2, 32'h0);
    send_item(sle_pkg::OP_READ,   7'd1, 32'h0);
    send_item(sle_pkg::OP_READ,   7'd2, 32'h0);
    drain_results();

    sent      = 0;
    seg_index = 0;
    while (sent < RANDOM_ITEMS) begin
      case (seg_index)
        0:       begin kind = SEG_MIX;    seg_len = 40;  end
        1:       begin kind = SEG_GROW;   seg_len = 110; end  // runs into a full list
        2:       begin kind = SEG_MIX;    seg_len = 60;  end
        3:       begin kind = SEG_SHRINK; seg_len = 130; end  // back down to empty
        default: begin
          kind    = segment_e'($urandom_range(0, 2));
          seg_len = $urandom_range(30, 90);
        end
      endcase
      if (seg_index == 4) begin
        // receiver holds off while requests keep coming, so the engine backs up
        long_hold_req <= 1'b1;
        gapless = 1'b1;
      end
      for (int n = 0; n < int'(seg_len) && sent < RANDOM_ITEMS; n++) begin
        if (seg_index == 4 && n == 40) gapless = 1'b0;
        send_item(pick_op(kind), pick_position(shadow_length), $urandom);
        sent++;
      end
      gapless = 1'b0;
      if (seg_index == 2 || $urandom_range(0, 3) == 0) drain_results();
      seg_index++;
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
